// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL files that carry concurrent checks.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/lir_pkg.sv -----
// Types and constants of the linear interpolation resampler.
// No dependencies; used by every other RTL file of the block except assert_macros.svh.
`default_nettype none

package lir_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int STEP_W     = 16;
  localparam int LIMIT_W    = 25;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 25;
  localparam int MAX_ITER   = 5;
  localparam int ITER_W     = 3;
  localparam int QUOT_W     = 16;
  localparam int DIV_STEPS  = QUOT_W / 2;
  localparam int DIV_CNT_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT = 1'b1;

  localparam logic [STEP_W-1:0]  STEP_RESET  = 16'd11025;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 25'd28800000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ADD,
    S_LOAD,
    S_DIV,
    S_STORE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic skip;
    logic add;
    logic load;
    logic div_step;
    logic store;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic phase_lt;
    logic count_lt;
    logic iter_lt;
    logic div_done;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/lir_in_if.sv -----
// Input channel of the resampler: valid/ready handshake with the input beat.
// Depends on lir_pkg for the sample width.
`default_nettype none

interface lir_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [lir_pkg::SAMPLE_W-1:0] sample_in;
  logic                           restart;

  modport source (output valid, output sample_in, output restart, input ready);
  modport sink (input valid, input sample_in, input restart, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/lir_out_if.sv -----
// Output channel of the resampler: valid/ready handshake with the result beat.
// Depends on lir_pkg for the sample width.
`default_nettype none

interface lir_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [lir_pkg::SAMPLE_W-1:0] sample_out;
  logic                           last;

  modport source (output valid, output sample_out, output last, input ready);
  modport sink (input valid, input sample_out, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/lir_ctrl.sv -----
// Controller state machine of the resampler: sequences the per-input loop.
// Depends on lir_pkg for the state, command and status types.
`default_nettype none

module lir_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  lir_pkg::sts_t   sts,
  output logic            in_ready,
  output lir_pkg::cmd_t   cmd
);

  lir_pkg::state_t state;
  lir_pkg::state_t state_next;

  logic emit_ok;
  logic loop_on;

  assign loop_on = sts.iter_lt && sts.phase_lt;
  assign emit_ok = !sts.pend_valid || sts.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lir_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lir_pkg::S_IDLE: begin
        if (in_valid) state_next = lir_pkg::S_CHECK;
      end
      lir_pkg::S_CHECK: begin
        if (!loop_on) begin
          state_next = lir_pkg::S_FINISH;
        end else if (sts.count_lt) begin
          state_next = lir_pkg::S_ADD;
        end
      end
      lir_pkg::S_ADD: state_next = lir_pkg::S_LOAD;
      lir_pkg::S_LOAD: state_next = lir_pkg::S_DIV;
      lir_pkg::S_DIV: begin
        if (sts.div_done) state_next = lir_pkg::S_STORE;
      end
      lir_pkg::S_STORE: begin
        if (emit_ok) state_next = lir_pkg::S_CHECK;
      end
      lir_pkg::S_FINISH: begin
        if (emit_ok) state_next = lir_pkg::S_IDLE;
      end
      default: state_next = lir_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      lir_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      lir_pkg::S_CHECK: begin
        cmd.mul  = loop_on && sts.count_lt;
        cmd.skip = loop_on && !sts.count_lt;
      end
      lir_pkg::S_ADD:    cmd.add = 1'b1;
      lir_pkg::S_LOAD:   cmd.load = 1'b1;
      lir_pkg::S_DIV:    cmd.div_step = 1'b1;
      lir_pkg::S_STORE:  cmd.store = emit_ok;
      lir_pkg::S_FINISH: cmd.finish = emit_ok;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/lir_dp.sv -----
// Datapath of the resampler: registers, phase accumulator, multiplier,
// radix-4 divider by the output rate and the output register. Uses lir_pkg.
`default_nettype none

module lir_dp #(
  parameter int OUT_RATE = 48000
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [lir_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lir_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic signed [lir_pkg::SAMPLE_W-1:0]   sample_in,
  input  logic                                  restart,
  input  lir_pkg::cmd_t                         cmd,
  output lir_pkg::sts_t                         sts,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic signed [lir_pkg::SAMPLE_W-1:0]   sample_out,
  output logic                                  last
);

  localparam int PW = $clog2(OUT_RATE + 65536);
  localparam int XW = PW + 18;
  localparam logic [PW-1:0]        RATE_P = PW'(OUT_RATE);
  localparam logic [XW-1:0]        RATE_U = XW'(OUT_RATE);
  localparam logic signed [XW-1:0] RATE_X = XW'(OUT_RATE);
  localparam logic [lir_pkg::DIV_CNT_W-1:0] DIV_LAST =
    lir_pkg::DIV_CNT_W'(lir_pkg::DIV_STEPS - 1);

  logic [lir_pkg::STEP_W-1:0]          phase_step;
  logic [lir_pkg::LIMIT_W-1:0]         output_limit;
  logic [PW-1:0]                       phase_acc;
  logic signed [lir_pkg::SAMPLE_W-1:0] prev_sample;
  logic signed [lir_pkg::SAMPLE_W-1:0] cur_sample;
  logic [lir_pkg::LIMIT_W-1:0]         out_count;
  logic [lir_pkg::ITER_W-1:0]          iter_cnt;
  logic signed [XW-1:0]                prod;
  logic signed [XW-1:0]                acc;
  logic [XW-1:0]                       rem;
  logic [lir_pkg::QUOT_W-1:0]          quot;
  logic                                neg;
  logic [lir_pkg::DIV_CNT_W-1:0]       div_cnt;
  logic [lir_pkg::SAMPLE_W-1:0]        pend_sample;
  logic                                pend_valid;

  logic signed [lir_pkg::SAMPLE_W:0]   diff;
  logic signed [PW:0]                  phase_s;
  logic signed [XW-1:0]                prod_c;
  logic signed [XW-1:0]                prev_x;
  logic [PW-1:0]                       phase_adv;
  logic [XW-1:0]                       trial0;
  logic [XW-1:0]                       trial1;
  logic [XW-1:0]                       rem0;
  logic [XW-1:0]                       rem1;
  logic                                bit0;
  logic                                bit1;
  logic [lir_pkg::QUOT_W-1:0]          result;

  assign diff    = (lir_pkg::SAMPLE_W + 1)'(cur_sample) - (lir_pkg::SAMPLE_W + 1)'(prev_sample);
  assign phase_s = $signed({1'b0, phase_acc});
  assign prod_c  = diff * phase_s;
  assign prev_x  = XW'(prev_sample);
  assign phase_adv = phase_acc + PW'(phase_step);

  always_comb begin
    trial0 = RATE_U << {~div_cnt, 1'b1};
    bit0   = rem >= trial0;
    rem0   = bit0 ? rem - trial0 : rem;
    trial1 = RATE_U << {~div_cnt, 1'b0};
    bit1   = rem0 >= trial1;
    rem1   = bit1 ? rem0 - trial1 : rem0;
  end

  assign result = neg ? lir_pkg::QUOT_W'(-quot) : quot;

  assign sts.phase_lt   = phase_acc < RATE_P;
  assign sts.count_lt   = out_count < output_limit;
  assign sts.iter_lt    = iter_cnt < lir_pkg::ITER_W'(lir_pkg::MAX_ITER);
  assign sts.div_done   = div_cnt == DIV_LAST;
  assign sts.pend_valid = pend_valid;
  assign sts.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step   <= lir_pkg::STEP_RESET;
      output_limit <= lir_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lir_pkg::CFG_PHASE_STEP:   phase_step <= cfg_data[lir_pkg::STEP_W-1:0];
        lir_pkg::CFG_OUTPUT_LIMIT: output_limit <= cfg_data[lir_pkg::LIMIT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc   <= '0;
      prev_sample <= '0;
      out_count   <= '0;
      iter_cnt    <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
      div_cnt     <= '0;
    end else begin
      if (out_ready) out_valid <= 1'b0;
      if (cmd.capture) begin
        iter_cnt <= '0;
        if (restart) begin
          phase_acc   <= '0;
          prev_sample <= '0;
          out_count   <= '0;
        end
      end
      if (cmd.mul) out_count <= out_count + 1'b1;
      if (cmd.skip) begin
        phase_acc <= phase_adv;
        iter_cnt  <= iter_cnt + 1'b1;
      end
      if (cmd.load) div_cnt <= '0;
      if (cmd.div_step) div_cnt <= div_cnt + 1'b1;
      if (cmd.store) begin
        if (pend_valid) out_valid <= 1'b1;
        pend_valid <= 1'b1;
        phase_acc  <= phase_adv;
        iter_cnt   <= iter_cnt + 1'b1;
      end
      if (cmd.finish) begin
        if (pend_valid) out_valid <= 1'b1;
        pend_valid  <= 1'b0;
        phase_acc   <= (phase_acc < RATE_P) ? '0 : phase_acc - RATE_P;
        prev_sample <= cur_sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) cur_sample <= sample_in;
    if (cmd.mul) prod <= prod_c;
    if (cmd.add) acc <= prod + prev_x * RATE_X;
    if (cmd.load) begin
      neg  <= acc[XW-1];
      rem  <= acc[XW-1] ? XW'(-acc) : XW'(acc);
      quot <= '0;
    end
    if (cmd.div_step) begin
      rem  <= rem1;
      quot <= {quot[lir_pkg::QUOT_W-3:0], bit0, bit1};
    end
    if (cmd.store) begin
      pend_sample <= result;
      if (pend_valid) begin
        sample_out <= pend_sample;
        last       <= 1'b0;
      end
    end
    if (cmd.finish && pend_valid) begin
      sample_out <= pend_sample;
      last       <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/linear_interp_resampler.sv -----
// An input beat holds the block from capture to its finish step, plus any output stall,
// and yields n results (0 to 5); loop steps that emit nothing only advance the phase.
// Each result passes through the radix-4 divider by OUT_RATE.
// A result leaves when the next result of the same input is stored, or at its end.
// Reset (rst, synchronous) clears phase, previous sample, count and all handshakes,
// and restores phase_step to 11025 and output_limit to 28800000.
`default_nettype none
`include "assert_macros.svh"

module linear_interp_resampler #(
  parameter int OUT_RATE = 48000
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lir_pkg::CFG_DATA_W-1:0] cfg_data,
  lir_in_if.sink                         in_ch,
  lir_out_if.source                      out_ch
);

  lir_pkg::cmd_t cmd;
  lir_pkg::sts_t sts;
  logic          in_ready;
  logic          out_valid;
  logic signed [lir_pkg::SAMPLE_W-1:0] sample_out;
  logic          last;

  lir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  lir_dp #(
    .OUT_RATE (OUT_RATE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (in_ch.sample_in),
    .restart    (in_ch.restart),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (out_ch.ready),
    .out_valid  (out_valid),
    .sample_out (sample_out),
    .last       (last)
  );

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid;
  assign out_ch.sample_out = sample_out;
  assign out_ch.last       = last;

  `ASSERT_NEXT(a_busy_after_beat, in_ch.valid && in_ready, !in_ready)
  `ASSERT_SAME(a_push_has_room, (cmd.store || cmd.finish) && sts.pend_valid, sts.out_free)
  `ASSERT_SAME(a_mul_in_loop, cmd.mul, sts.phase_lt && sts.count_lt && sts.iter_lt)

endmodule

`default_nettype wire
